>>> design/keyed_wait_queue_top_macros.svh
// Assertion macros for the wait-queue checker.
`ifndef KEYED_WAIT_QUEUE_TOP_MACROS_SVH
`define KEYED_WAIT_QUEUE_TOP_MACROS_SVH

// Implication in the same cycle.
`define KWQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define KWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kwq_pkg.sv
// Package: types, codes and field layout of the keyed wait queue.
`default_nettype none
package kwq_pkg;

  localparam int MAX_WAITERS_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int MAX_RESULTS        = 16;
  localparam int ADDR_W             = 64;
  localparam int WORD_W             = 32;
  localparam int TID_W              = 8;
  localparam int TOTAL_W            = 5;

  localparam int IN_TID_LSB   = 0;
  localparam int IN_USER_BIT  = 8;
  localparam int IN_ADDR_LSB  = 9;
  localparam int IN_WORD_LSB  = 73;
  localparam int IN_EXP_LSB   = 105;
  localparam int IN_MAXC_LSB  = 137;
  localparam int IN_TDATA_W   = 176;

  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_VALID_BIT  = 2;
  localparam int OUT_THREAD_LSB = 3;
  localparam int OUT_TOTAL_LSB  = 11;
  localparam int OUT_TDATA_W    = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USER = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    ACT_WAIT = 1'b0,
    ACT_WAKE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage
`default_nettype wire

>>> design/keyed_wait_queue_top.sv
// Keyed wait queue: waiters kept in arrival order, released by address.
//
// Input channel in_*: one transfer per wait or wake request; in_tuser is the
// action (0 wait, 1 wake). Output channel out_*: one transfer per result;
// out_tlast marks the final result of a request.
// A wait, or any request from a non-user caller, gives one result, which passes
// through the S_RESP state into the result register.
// A wake walks the waiter memory one entry per cycle while no stalled result
// blocks it, bound by the single read port of the waiter memory, and writes
// kept entries back compacted. Each released thread gives one result; the
// last one carries the total. A wake that releases nobody gives one empty
// result.
// One request is in flight at a time: in_tready is high only while idle.
// When the receiver stalls, the result register holds and the scan pauses
// at the next match until the register frees.
// Reset empties the queue at once; memory contents are not cleared.
`default_nettype none
module keyed_wait_queue_top
  import kwq_pkg::*;
#(
  parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // action
  input  wire logic                   in_tuser,
  // thread_id, is_user_thread, address, memory_word, expected, wake_limit, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // status, woken_valid, woken_thread, woken_total
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  localparam int IDX_W = $clog2(MAX_WAITERS);
  localparam int ENT_W = THREAD_ID_BITS + ADDR_W;

  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0] mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;

  kwq_engine #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  kwq_mem #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule
`default_nettype wire

>>> design/kwq_mem.sv
// Waiter memory: one write port, one registered read port.
`default_nettype none
module kwq_mem
  import kwq_pkg::*;
#(
  parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  localparam int IDX_W         = $clog2(MAX_WAITERS),
  localparam int ENT_W         = THREAD_ID_BITS + ADDR_W
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [ENT_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [ENT_W-1:0] wr_data
);

  logic [ENT_W-1:0] mem_q [MAX_WAITERS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> design/kwq_engine.sv
// Engine: command decode, append, scan-and-compact wake, result register.
`default_nettype none
module kwq_engine
  import kwq_pkg::*;
#(
  parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF,
  localparam int IDX_W         = $clog2(MAX_WAITERS),
  localparam int CNT_W         = $clog2(MAX_WAITERS + 1),
  localparam int ENT_W         = THREAD_ID_BITS + ADDR_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic                   in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        mem_rd_en,
  output logic      [IDX_W-1:0]       mem_rd_addr,
  input  wire logic [ENT_W-1:0]       mem_rd_data,
  output logic                        mem_wr_en,
  output logic      [IDX_W-1:0]       mem_wr_addr,
  output logic      [ENT_W-1:0]       mem_wr_data
);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      user_r;
  logic                      eq_r;
  logic [THREAD_ID_BITS-1:0] tid_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [TOTAL_W-1:0]        limit_r;
  logic [CNT_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]          keep_r, keep_nxt;
  logic                      have_r, have_nxt;
  logic [TOTAL_W-1:0]        n_r, n_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic [THREAD_ID_BITS-1:0] pend_thread_r, pend_thread_nxt;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic                      out_last_r;

  logic                      accept;
  logic                      out_free;
  logic                      hit;
  logic                      adv;
  logic                      more;
  logic [THREAD_ID_BITS+7:0] in_tid_ext;
  logic [THREAD_ID_BITS+7:0] pend_tid_ext;
  logic [WORD_W-1:0]         in_maxc;
  logic [TOTAL_W-1:0]        in_limit;
  logic [THREAD_ID_BITS-1:0] ent_thread;
  logic [ADDR_W-1:0]         ent_addr;

  logic                      push;
  status_t                   push_status;
  logic                      push_valid;
  logic [TID_W-1:0]          push_thread;
  logic [TOTAL_W-1:0]        push_total;
  logic                      push_last;

  assign accept       = in_tvalid && in_tready;
  assign in_tready    = (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_tready;
  assign in_tid_ext   = {{THREAD_ID_BITS{1'b0}}, in_tdata[IN_TID_LSB +: TID_W]};
  assign pend_tid_ext = {{TID_W{1'b0}}, pend_thread_r};
  assign in_maxc      = in_tdata[IN_MAXC_LSB +: WORD_W];
  assign in_limit     = (in_maxc < WORD_W'(MAX_RESULTS)) ? in_maxc[TOTAL_W-1:0]
                                                         : TOTAL_W'(MAX_RESULTS);
  assign ent_thread   = mem_rd_data[THREAD_ID_BITS-1:0];
  assign ent_addr     = mem_rd_data[THREAD_ID_BITS +: ADDR_W];
  assign hit          = have_r && (ent_addr == addr_r) && (n_r < limit_r);
  assign adv          = !(hit && pend_valid_r && !out_free);
  assign more         = (rd_idx_r < count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == ACT_WAKE && in_tdata[IN_USER_BIT]) ? S_SCAN : S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (adv && !more) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    keep_nxt        = keep_r;
    have_nxt        = have_r;
    n_nxt           = n_r;
    pend_valid_nxt  = pend_valid_r;
    pend_thread_nxt = pend_thread_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = rd_idx_r[IDX_W-1:0];
    mem_wr_en       = 1'b0;
    mem_wr_addr     = keep_r[IDX_W-1:0];
    mem_wr_data     = mem_rd_data;
    push            = 1'b0;
    push_status     = ST_OK;
    push_valid      = 1'b0;
    push_thread     = '0;
    push_total      = '0;
    push_last       = 1'b1;
    case (state_r)
      S_IDLE: begin
        rd_idx_nxt     = '0;
        keep_nxt       = '0;
        have_nxt       = 1'b0;
        n_nxt          = '0;
        pend_valid_nxt = 1'b0;
      end
      S_RESP: begin
        if (!user_r) begin
          push_status = ST_NOT_USER;
        end else if (!eq_r) begin
          push_status = ST_MISMATCH;
        end else if (count_r >= CNT_W'(MAX_WAITERS)) begin
          push_status = ST_FULL;
        end else begin
          push_status = ST_OK;
        end
        if (out_free) begin
          push = 1'b1;
          if (push_status == ST_OK) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = count_r[IDX_W-1:0];
            mem_wr_data = {addr_r, tid_r};
            count_nxt   = count_r + CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (adv) begin
          if (have_r) begin
            if (hit) begin
              n_nxt           = n_r + TOTAL_W'(1);
              pend_valid_nxt  = 1'b1;
              pend_thread_nxt = ent_thread;
              if (pend_valid_r) begin
                push        = 1'b1;
                push_valid  = 1'b1;
                push_thread = pend_tid_ext[TID_W-1:0];
                push_total  = n_r;
                push_last   = 1'b0;
              end
            end else begin
              mem_wr_en = 1'b1;
              keep_nxt  = keep_r + CNT_W'(1);
            end
          end
          mem_rd_en = more;
          have_nxt  = more;
          if (more) begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          count_nxt = keep_r;
          if (pend_valid_r) begin
            push_valid  = 1'b1;
            push_thread = pend_tid_ext[TID_W-1:0];
            push_total  = n_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    keep_r        <= keep_nxt;
    have_r        <= have_nxt;
    n_r           <= n_nxt;
    pend_valid_r  <= pend_valid_nxt;
    pend_thread_r <= pend_thread_nxt;
    if (accept) begin
      user_r  <= in_tdata[IN_USER_BIT];
      eq_r    <= (in_tdata[IN_WORD_LSB +: WORD_W] == in_tdata[IN_EXP_LSB +: WORD_W]);
      tid_r   <= in_tid_ext[THREAD_ID_BITS-1:0];
      addr_r  <= in_tdata[IN_ADDR_LSB +: ADDR_W];
      limit_r <= in_limit;
    end
    if (push) begin
      out_data_r <= {push_total, push_thread, push_valid, push_status};
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> design/kwq_checker.sv
// Port-level checker for the keyed wait queue, bound to the top level.
`default_nettype none
`include "keyed_wait_queue_top_macros.svh"
module kwq_checker
  import kwq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  `KWQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `KWQ_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `KWQ_ASSERT_SAME(a_empty_is_last, out_tvalid && !out_tdata[OUT_VALID_BIT], out_tlast, "empty result not last")
  `KWQ_ASSERT_SAME(a_err_empty, out_tvalid && (out_tdata[OUT_STATUS_LSB +: 2] != ST_OK), out_tdata[OUT_TDATA_W-1:OUT_VALID_BIT] == '0, "error result carries a thread")

endmodule

bind keyed_wait_queue_top kwq_checker u_kwq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
